// File: rtl/tick_interval_timer_with_debounce_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef TICK_INTERVAL_TIMER_WITH_DEBOUNCE_UNIT_DEFINES_SVH
`define TICK_INTERVAL_TIMER_WITH_DEBOUNCE_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define TITD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TITD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/titd_pkg.sv
package titd_pkg;

	localparam int BLINK_PERIOD      = 400;
	localparam int TICKS_PER_TENTH   = 10;
	localparam int TENTHS_PER_SECOND = 10;
	localparam int DEBOUNCE_TICKS    = 5;

	localparam int BTN_W   = 4;
	localparam int BLINK_W = 9;
	localparam int TICK_W  = 4;
	localparam int TENTH_W = 4;
	localparam int SEC_W   = 15;
	localparam int HOLD_W  = 3;
	localparam int EVT_W   = 3;

	localparam logic [SEC_W-1:0] INTERVAL_RESET = 15'd10;

	typedef enum logic [EVT_W-1:0] {
		EVT_NONE   = 3'd0,
		EVT_ENTER  = 3'd1,
		EVT_CANCEL = 3'd2,
		EVT_UP     = 3'd3,
		EVT_DOWN   = 3'd4
	} evt_t;

	typedef struct packed {
		evt_t evt;
		logic dirty;
	} dbn_res_t;

endpackage

// File: rtl/titd_debounce.sv
module titd_debounce (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [titd_pkg::BTN_W-1:0]   buttons_n,
	output titd_pkg::dbn_res_t           res
);

	logic [titd_pkg::HOLD_W-1:0] hold_q, hold_d;
	logic                        rep_q, rep_d;
	logic [titd_pkg::BTN_W-1:0]  pressed;
	titd_pkg::evt_t              dec;

	assign pressed = ~buttons_n;

	always_comb begin
		case (pressed)
			4'b0001: dec = titd_pkg::EVT_ENTER;
			4'b0010: dec = titd_pkg::EVT_CANCEL;
			4'b0100: dec = titd_pkg::EVT_UP;
			4'b1000: dec = titd_pkg::EVT_DOWN;
			default: dec = titd_pkg::EVT_NONE;
		endcase
	end

	always_comb begin
		hold_d    = hold_q;
		rep_d     = rep_q;
		res.evt   = titd_pkg::EVT_NONE;
		res.dirty = 1'b0;
		if (pressed != '0) begin
			res.dirty = 1'b1;
			if (hold_q < titd_pkg::HOLD_W'(titd_pkg::DEBOUNCE_TICKS))
				hold_d = hold_q + 1'b1;
			if (hold_d >= titd_pkg::HOLD_W'(titd_pkg::DEBOUNCE_TICKS) && !rep_q) begin
				res.evt = dec;
				rep_d   = 1'b1;
			end
		end else begin
			hold_d = '0;
			rep_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			rep_q  <= 1'b0;
		end else if (adv) begin
			hold_q <= hold_d;
			rep_q  <= rep_d;
		end
	end

endmodule

// File: rtl/tick_interval_timer_with_debounce_unit.sv
// Tick timer with button debounce. Each input beat is one 10 ms tick carrying
// the raw active-low levels of four buttons; each tick yields exactly one output
// beat with the blink pulse, the interval trigger, the debounced button event,
// the display-dirty flag and the seconds count after that tick. A tick goes
// through an input register and then a result register before its result
// beat is offered, and one tick per clock is sustained; the only stall comes
// from m_axis_tready. The interval register (reset 10 s) is written through
// the cfg channel, which is always ready; write it only while no tick is in
// flight.
`include "tick_interval_timer_with_debounce_unit_defines.svh"

module tick_interval_timer_with_debounce_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [3:0] buttons_n, [7:4] zero

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] led_pulse, [1] trigger_pulse, [4:2] button_event, [5] display_dirty,
	// [20:6] seconds_count, [23:21] zero
	output logic [23:0] m_axis_tdata,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int BW = titd_pkg::BLINK_W;
	localparam int TW = titd_pkg::TICK_W;
	localparam int NW = titd_pkg::TENTH_W;
	localparam int SW = titd_pkg::SEC_W;

	logic                       vld_s1;
	logic [titd_pkg::BTN_W-1:0] btn_s1;
	logic                       vld_s2;
	logic [23:0]                res_s2;
	logic                       adv;

	logic [SW-1:0] interval_q;
	logic [BW-1:0] blink_q;
	logic [TW-1:0] tick_q;
	logic [NW-1:0] tenth_q;
	logic [SW-1:0] sec_q;

	logic [BW:0]   blink_n;
	logic          led;
	logic [TW:0]   tick_n;
	logic          tick_wrap;
	logic [NW:0]   tenth_n;
	logic          tenth_wrap;
	logic [SW:0]   sec_n;
	logic          trig;
	logic [SW-1:0] sec_d;

	titd_pkg::dbn_res_t dbn;

	assign cfg_ready     = 1'b1;
	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = res_s2;

	always_comb begin
		blink_n    = {1'b0, blink_q} + 1'b1;
		led        = blink_n >= (BW+1)'(titd_pkg::BLINK_PERIOD);
		tick_n     = {1'b0, tick_q} + 1'b1;
		tick_wrap  = tick_n >= (TW+1)'(titd_pkg::TICKS_PER_TENTH);
		tenth_n    = {1'b0, tenth_q} + (NW+1)'(tick_wrap);
		tenth_wrap = tenth_n >= (NW+1)'(titd_pkg::TENTHS_PER_SECOND);
		sec_n      = {1'b0, sec_q} + (SW+1)'(tenth_wrap);
		trig       = sec_n >= {1'b0, interval_q};
		sec_d      = trig ? '0 : sec_n[SW-1:0];
	end

	titd_debounce u_dbn (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.buttons_n (btn_s1),
		.res       (dbn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= titd_pkg::INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= '0;
			tick_q  <= '0;
			tenth_q <= '0;
			sec_q   <= '0;
		end else if (adv) begin
			blink_q <= led ? '0 : blink_n[BW-1:0];
			tick_q  <= tick_wrap ? '0 : tick_n[TW-1:0];
			tenth_q <= tenth_wrap ? '0 : tenth_n[NW-1:0];
			sec_q   <= sec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				vld_s1 <= s_axis_tvalid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (m_axis_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			btn_s1 <= s_axis_tdata[titd_pkg::BTN_W-1:0];
		if (adv)
			res_s2 <= {3'b000, sec_d, dbn.dirty, dbn.evt, trig, led};
	end

	`TITD_ASSERT(a_trig_clears,
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[20:6] == '0,
		"trigger beat must carry a cleared seconds count")
	`TITD_ASSERT(a_evt_dirty,
		m_axis_tvalid && m_axis_tdata[4:2] != '0 |-> m_axis_tdata[5],
		"button event without display dirty")
	`TITD_ASSERT(a_cascade_range,
		tick_q < TW'(titd_pkg::TICKS_PER_TENTH) && tenth_q < NW'(titd_pkg::TENTHS_PER_SECOND),
		"tick cascade out of range")
	`TITD_ASSERT(a_hold_result, vld_s2 && !m_axis_tready |=> vld_s2, "result dropped while stalled")
	`TITD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_axis_tvalid, "result beat right after reset")

endmodule
